/* hdl/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types for the merge sort engine: port widths,
// default sizes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int IO_BITS            = 32;
    localparam int DEPTH_DEFAULT      = 1024;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_MERGE = 3'b100
    } state_t;

endpackage

/* hdl/merge_sort_engine_core.sv */
// ----------------------------------------------------------------------------
// merge_sort_engine_core
// Stable ascending merge sort of signed values held in two on-chip stores.
//
// A command transfers when start is high and busy is low. op = load writes
// value into the element store, or drops it and sets overflow when the
// store is full; a load with last set closes the set and starts the sort if
// the set holds two or more values. A load after a closed set opens a new
// set. op = fetch returns the next sorted value in the cycle after the
// transfer, on sorted_value with last_of_run, nothing_left and overflowed,
// marked by result_valid for exactly one cycle; the receiver cannot stall
// it. An open or exhausted set gives zero with nothing_left. Loads and
// fetches may follow back to back when busy is low. The sort runs
// bottom-up merge passes between the two stores, one element a cycle, with
// a set-up step before each pair of runs; the merge loop writes one store
// and reads two entries of the other each cycle. busy is high for the sort.
// Reset clears the count, read pointer, flags and sequencer; the stores are
// not cleared, and every entry is written before it is read.
// ----------------------------------------------------------------------------
module merge_sort_engine_core
    import mse_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      op,
    input  logic signed [IO_BITS-1:0] value,
    input  logic                      last,
    output logic                      result_valid,
    output logic signed [IO_BITS-1:0] sorted_value,
    output logic                      last_of_run,
    output logic                      nothing_left,
    output logic                      overflowed
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WW    = CNT_W + 1;
    localparam int SW    = CNT_W + 2;

    // stores: element store and merge scratch
    logic [VALUE_BITS-1:0] mem_a [DEPTH];
    logic [VALUE_BITS-1:0] mem_b [DEPTH];

    logic [VALUE_BITS-1:0] a_rd0_reg, a_rd1_reg, b_rd0_reg, b_rd1_reg;
    logic [AW-1:0]         addr_rd0, addr_rd1, wr_addr;
    logic [VALUE_BITS-1:0] wr_data, load_data, left_val, right_val, merge_data;
    logic                  wr_a, wr_b;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rp_reg, rp_next;
    logic                closed_reg, closed_next;
    logic                ovf_reg, ovf_next;
    logic                in_scratch_reg, in_scratch_next;
    logic                src_b_reg, src_b_next;
    logic [WW-1:0]       width_reg, width_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic                res_valid_reg, res_valid_next;
    logic                res_last_reg, res_last_next;
    logic                res_empty_reg, res_empty_next;
    logic                res_ovf_reg, res_ovf_next;

    logic                accept;
    logic [CNT_W-1:0]    eff_cnt;
    logic [SW-1:0]       sum_lo, sum_mid;
    logic [CNT_W-1:0]    mid_c, hi_c;
    logic                left_ok, right_ok, take_left;
    logic [VALUE_BITS-1:0] fetch_data;
    logic [IO_BITS-1:0]  fetch_ext;

    // width adaption between ports and stores
    generate
        if (VALUE_BITS > IO_BITS) begin : g_wide
            assign load_data = {{(VALUE_BITS-IO_BITS){1'b0}}, value};
            assign fetch_ext = fetch_data[IO_BITS-1:0];
        end else if (VALUE_BITS == IO_BITS) begin : g_equal
            assign load_data = value;
            assign fetch_ext = fetch_data;
        end else begin : g_narrow
            assign load_data = value[VALUE_BITS-1:0];
            assign fetch_ext = {{(IO_BITS-VALUE_BITS){fetch_data[VALUE_BITS-1]}}, fetch_data};
        end
    endgenerate

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign left_val   = src_b_reg ? b_rd0_reg : a_rd0_reg;
    assign right_val  = src_b_reg ? b_rd1_reg : a_rd1_reg;
    assign left_ok    = (i_reg < mid_reg);
    assign right_ok   = (j_reg < hi_reg);
    assign take_left  = left_ok && (!right_ok || ($signed(left_val) <= $signed(right_val)));
    assign merge_data = take_left ? left_val : right_val;

    assign sum_lo  = SW'(lo_reg) + SW'(width_reg);
    assign mid_c   = (sum_lo < SW'(count_reg)) ? sum_lo[CNT_W-1:0] : count_reg;
    assign sum_mid = SW'(mid_c) + SW'(width_reg);
    assign hi_c    = (sum_mid < SW'(count_reg)) ? sum_mid[CNT_W-1:0] : count_reg;

    assign eff_cnt = closed_reg ? '0 : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rp_next         = rp_reg;
        closed_next     = closed_reg;
        ovf_next        = ovf_reg;
        in_scratch_next = in_scratch_reg;
        src_b_next      = src_b_reg;
        width_next      = width_reg;
        lo_next         = lo_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        mid_next        = mid_reg;
        hi_next         = hi_reg;
        res_valid_next  = 1'b0;
        res_last_next   = res_last_reg;
        res_empty_next  = res_empty_reg;
        res_ovf_next    = res_ovf_reg;
        addr_rd0        = i_reg[AW-1:0];
        addr_rd1        = j_reg[AW-1:0];
        wr_a            = 1'b0;
        wr_b            = 1'b0;
        wr_addr         = k_reg[AW-1:0];
        wr_data         = merge_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                addr_rd0 = rp_reg[AW-1:0];
                if (accept && op == OP_LOAD)
                begin
                    if (closed_reg)
                    begin
                        rp_next     = '0;
                        ovf_next    = 1'b0;
                        closed_next = 1'b0;
                    end
                    if (eff_cnt < CNT_W'(DEPTH))
                    begin
                        wr_a       = 1'b1;
                        wr_addr    = eff_cnt[AW-1:0];
                        wr_data    = load_data;
                        count_next = eff_cnt + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = eff_cnt;
                        ovf_next   = 1'b1;
                    end
                    if (last)
                    begin
                        rp_next     = '0;
                        closed_next = 1'b1;
                        if (count_next >= CNT_W'(2))
                        begin
                            width_next = WW'(1);
                            lo_next    = '0;
                            src_b_next = 1'b0;
                            state_next = ST_RUN;
                        end
                        else
                        begin
                            in_scratch_next = 1'b0;
                        end
                    end
                end
                else if (accept && op == OP_FETCH)
                begin
                    res_valid_next = 1'b1;
                    res_ovf_next   = ovf_reg;
                    if (!closed_reg || rp_reg >= count_reg)
                    begin
                        res_empty_next = 1'b1;
                        res_last_next  = 1'b0;
                    end
                    else
                    begin
                        res_empty_next = 1'b0;
                        res_last_next  = ((rp_reg + CNT_W'(1)) == count_reg);
                        rp_next        = rp_reg + CNT_W'(1);
                    end
                end
            end

            ST_RUN:
            begin
                mid_next   = mid_c;
                hi_next    = hi_c;
                i_next     = lo_reg;
                j_next     = mid_c;
                k_next     = lo_reg;
                addr_rd0   = lo_reg[AW-1:0];
                addr_rd1   = mid_c[AW-1:0];
                state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                wr_a     = src_b_reg;
                wr_b     = !src_b_reg;
                i_next   = take_left ? i_reg + CNT_W'(1) : i_reg;
                j_next   = take_left ? j_reg : j_reg + CNT_W'(1);
                k_next   = k_reg + CNT_W'(1);
                addr_rd0 = i_next[AW-1:0];
                addr_rd1 = j_next[AW-1:0];
                if (k_next == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = ST_RUN;
                    if (hi_reg == count_reg)
                    begin
                        // pass complete
                        lo_next    = '0;
                        src_b_next = !src_b_reg;
                        width_next = {width_reg[WW-2:0], 1'b0};
                        if (SW'({width_reg, 1'b0}) >= SW'(count_reg))
                        begin
                            in_scratch_next = !src_b_reg;
                            state_next      = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rp_reg         <= '0;
            closed_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
            in_scratch_reg <= 1'b0;
            src_b_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rp_reg         <= rp_next;
            closed_reg     <= closed_next;
            ovf_reg        <= ovf_next;
            in_scratch_reg <= in_scratch_next;
            src_b_reg      <= src_b_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        lo_reg        <= lo_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        res_last_reg  <= res_last_next;
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        a_rd0_reg <= mem_a[addr_rd0];
        a_rd1_reg <= mem_a[addr_rd1];
    end

    // merge scratch
    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        b_rd0_reg <= mem_b[addr_rd0];
        b_rd1_reg <= mem_b[addr_rd1];
    end

    assign fetch_data   = in_scratch_reg ? b_rd0_reg : a_rd0_reg;
    assign result_valid = res_valid_reg;
    assign sorted_value = res_empty_reg ? '0 : $signed(fetch_ext);
    assign last_of_run  = res_last_reg;
    assign nothing_left = res_empty_reg;
    assign overflowed   = res_ovf_reg;

    // a result only follows a fetch transfer
    a_result_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && op == OP_FETCH))
        else $error("result without fetch transfer");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(nothing_left && last_of_run))
        else $error("empty result marked last");

    a_sort_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg >= CNT_W'(2) && closed_reg))
        else $error("sort running on short or open set");

    a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MERGE |-> (k_reg < hi_reg && (left_ok || right_ok)))
        else $error("merge index beyond run");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for merge_sort_engine_core. Load and fetch commands
// are sent in bursts with random gaps. A local mirror of the engine keeps
// each set in arrival order, sorts it stably when the set closes, and
// predicts the fetch answers; a short directed table gives its own for
// empty, exhausted and open-set fetches and the value extremes. The random
// part then runs many small sets and one set loaded beyond capacity.
// ----------------------------------------------------------------------------
module testbench;
    import mse_pkg::*;

    localparam int                 RANDOM_ITEMS = 1450;
    localparam int                 DIRECTED_LEN = 25;
    localparam logic [IO_BITS-1:0] MIN_V        = 32'h8000_0000;
    localparam logic [IO_BITS-1:0] MAX_V        = 32'h7FFF_FFFF;
    localparam logic [IO_BITS-1:0] MINUS_ONE    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [IO_BITS-1:0] sorted_value;
        logic               last_of_run;
        logic               nothing_left;
        logic               overflowed;
    } result_t;

    typedef struct packed {
        logic               op;
        logic [IO_BITS-1:0] value;
        logic               last;
        logic               typed;
        result_t            want;
    } cmd_row_t;

    localparam result_t NO_ANSWER    = '0;
    localparam result_t EMPTY_ANSWER = '{32'h0, 1'b0, 1'b1, 1'b0};

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      op;
    logic signed [IO_BITS-1:0] value;
    logic                      last;
    logic                      result_valid;
    logic signed [IO_BITS-1:0] sorted_value;
    logic                      last_of_run;
    logic                      nothing_left;
    logic                      overflowed;

    // mirror of the engine
    logic [IO_BITS-1:0] arrival_vals[$];
    logic [IO_BITS-1:0] sorted_vals[$];
    int                 read_index;
    bit                 overflow_flag;
    bit                 set_closed;

    result_t fetch_answers_q[$];
    result_t head_answer;

    int fail_count;
    int burst_left;
    int total_items;
    int load_count;
    int fetch_count;
    int sets_sorted;
    int largest_set;
    int dropped_loads;
    int answers_checked;

    cmd_row_t directed_rows [DIRECTED_LEN] = '{
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, EMPTY_ANSWER},
        '{OP_LOAD,  MAX_V,        1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  MIN_V,        1'b0, 1'b0, NO_ANSWER},
        '{OP_FETCH, 32'h0,        1'b1, 1'b1, EMPTY_ANSWER},
        '{OP_LOAD,  32'h0,        1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  MINUS_ONE,    1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  MIN_V,        1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  MAX_V,        1'b1, 1'b0, NO_ANSWER},
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, '{MIN_V, 1'b0, 1'b0, 1'b0}},
        '{OP_FETCH, MAX_V,        1'b0, 1'b1, '{MIN_V, 1'b0, 1'b0, 1'b0}},
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, '{MINUS_ONE, 1'b0, 1'b0, 1'b0}},
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, '{MAX_V, 1'b0, 1'b0, 1'b0}},
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, '{MAX_V, 1'b1, 1'b0, 1'b0}},
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, EMPTY_ANSWER},
        '{OP_FETCH, 32'h5A5A_A5A5, 1'b1, 1'b1, EMPTY_ANSWER},
        '{OP_LOAD,  32'h5,        1'b1, 1'b0, NO_ANSWER},
        '{OP_FETCH, 32'h0,        1'b0, 1'b1, '{32'h5, 1'b1, 1'b0, 1'b0}},
        '{OP_LOAD,  32'hFFFF_FFF9, 1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  32'h3,        1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  32'hFFFF_FFF9, 1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  32'h3,        1'b1, 1'b0, NO_ANSWER},
        '{OP_FETCH, 32'h0,        1'b0, 1'b0, NO_ANSWER},
        '{OP_LOAD,  32'h1,        1'b1, 1'b0, NO_ANSWER},
        '{OP_FETCH, 32'h0,        1'b0, 1'b0, NO_ANSWER}
    };

    merge_sort_engine_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last_of_run  (last_of_run),
        .nothing_left (nothing_left),
        .overflowed   (overflowed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // stable ascending order: each value goes after all values not greater
    function automatic void order_closed_set();
        int pos;
        sorted_vals.delete();
        foreach (arrival_vals[k])
        begin
            pos = sorted_vals.size();
            while (pos > 0 && $signed(sorted_vals[pos-1]) > $signed(arrival_vals[k]))
                pos--;
            sorted_vals.insert(pos, arrival_vals[k]);
        end
    endfunction

    function automatic void mirror_command(input logic c_op, input logic [IO_BITS-1:0] c_value,
                                           input logic c_last, output bit gives,
                                           output result_t answer);
        answer = EMPTY_ANSWER;
        gives  = 1'b0;
        if (c_op == OP_LOAD)
        begin
            if (set_closed)
            begin
                arrival_vals.delete();
                sorted_vals.delete();
                read_index    = 0;
                overflow_flag = 1'b0;
                set_closed    = 1'b0;
            end
            if (arrival_vals.size() < DEPTH_DEFAULT)
                arrival_vals.push_back(c_value);
            else
            begin
                overflow_flag = 1'b1;
                dropped_loads++;
            end
            if (c_last)
            begin
                order_closed_set();
                read_index = 0;
                set_closed = 1'b1;
                sets_sorted++;
                if (arrival_vals.size() > largest_set)
                    largest_set = arrival_vals.size();
            end
        end
        else
        begin
            gives = 1'b1;
            answer.overflowed = overflow_flag;
            if (set_closed && read_index < sorted_vals.size())
            begin
                answer.sorted_value = sorted_vals[read_index];
                answer.last_of_run  = (read_index + 1 == sorted_vals.size());
                answer.nothing_left = 1'b0;
                read_index++;
            end
        end
    endfunction

    task automatic issue(input logic c_op, input logic [IO_BITS-1:0] c_value, input logic c_last,
                         input logic typed, input result_t want);
        bit      gives;
        result_t answer;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        op    <= c_op;
        value <= c_value;
        last  <= c_last;
        do @(posedge clk); while (busy);
        // transfer taken by this edge
        mirror_command(c_op, c_value, c_last, gives, answer);
        if (gives)
            fetch_answers_q.push_back(typed ? want : answer);
        total_items++;
        if (c_op == OP_LOAD)
            load_count++;
        else
            fetch_count++;
    endtask

    function automatic logic [IO_BITS-1:0] pick_value(input int style);
        logic [IO_BITS-1:0] v;
        case (style)
            0:       v = $urandom;
            1:       v = $urandom_range(0, 15) - 8;
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       v = MIN_V;
                    1:       v = MAX_V;
                    2:       v = 32'h0;
                    3:       v = MINUS_ONE;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom & 32'hFFFF_0003;
        endcase
        return v;
    endfunction

    task automatic run_set(input int n_loads, input int n_fetches, input bit noisy);
        int style;
        style = $urandom_range(0, 3);
        for (int k = 0; k < n_loads; k++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                issue(OP_FETCH, $urandom, 1'($urandom_range(0, 1)), 1'b0, NO_ANSWER);
            issue(OP_LOAD, pick_value(style), k == n_loads - 1, 1'b0, NO_ANSWER);
        end
        for (int k = 0; k < n_fetches; k++)
            issue(OP_FETCH, $urandom, 1'($urandom_range(0, 1)), 1'b0, NO_ANSWER);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (fetch_answers_q.size() == 0)
            begin
                $error("result with nothing expected: sorted_value %h", sorted_value);
                fail_count++;
            end
            else
            begin
                head_answer = fetch_answers_q.pop_front();
                answers_checked++;
                if (sorted_value !== head_answer.sorted_value)
                begin
                    $error("sorted_value: expected %h, got %h",
                           head_answer.sorted_value, sorted_value);
                    fail_count++;
                end
                if (last_of_run !== head_answer.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           head_answer.last_of_run, last_of_run);
                    fail_count++;
                end
                if (nothing_left !== head_answer.nothing_left)
                begin
                    $error("nothing_left: expected %b, got %b",
                           head_answer.nothing_left, nothing_left);
                    fail_count++;
                end
                if (overflowed !== head_answer.overflowed)
                begin
                    $error("overflowed: expected %b, got %b",
                           head_answer.overflowed, overflowed);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int  n_loads;
        int  n_fetches;
        bit  big_done;
        start         = 1'b0;
        op            = OP_LOAD;
        value         = '0;
        last          = 1'b0;
        rst_n         = 1'b0;
        read_index    = 0;
        overflow_flag = 1'b0;
        set_closed    = 1'b0;
        big_done      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            issue(directed_rows[r].op, directed_rows[r].value, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].want);

        while (total_items < DIRECTED_LEN + RANDOM_ITEMS || !big_done)
        begin
            if (!big_done && total_items >= 200)
            begin
                // fill past capacity, closing on a dropped load
                run_set(DEPTH_DEFAULT + $urandom_range(1, 3), 40, 1'b0);
                big_done = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       n_loads = 1;
                    7, 8:    n_loads = $urandom_range(17, 48);
                    9:       n_loads = $urandom_range(49, 160);
                    default: n_loads = $urandom_range(2, 16);
                endcase
                // mostly read the whole set and a little past it
                n_fetches = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_loads)
                                                         : n_loads + $urandom_range(0, 2);
                run_set(n_loads, n_fetches, 1'b1);
            end
        end
        start <= 1'b0;

        while (fetch_answers_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fetch_answers_q.size() != 0)
        begin
            $error("%0d fetch answers never arrived", fetch_answers_q.size());
            fail_count++;
        end

        $display("covered %0d loads and %0d fetches over %0d sorted sets, largest set %0d",
                 load_count, fetch_count, sets_sorted, largest_set);
        $display("%0d answers checked, %0d loads dropped beyond capacity",
                 answers_checked, dropped_loads);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* merge_sort_engine_core.f */
hdl/mse_pkg.sv
hdl/merge_sort_engine_core.sv
bench/testbench.sv
